// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: sv/ntnh_pkg.sv
// Shared types and constants of the neighbor table next-hop selector.
package ntnh_pkg;

  // Request codes; code 3 is unused and ignored.
  localparam logic [1:0] REQ_BEACON    = 2'd0;
  localparam logic [1:0] REQ_ORIGINATE = 2'd1;
  localparam logic [1:0] REQ_RELAY     = 2'd2;

  localparam logic [7:0] HOP_LIMIT_RESET = 8'd20;
  localparam int         RAND_W          = 16;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] neighbor_addr;
    logic [7:0]  hop_count;
    logic [15:0] rand_value;
  } in_pay_t;

  typedef struct packed {
    logic        send_now;
    logic [15:0] next_hop;
    logic [7:0]  out_hops;
    logic [15:0] seq_number;
    logic        no_neighbor;
    logic        was_added;
    logic        limit_reached;
  } out_pay_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_WRITE,
    ST_DIV,
    ST_PICK,
    ST_FINISH
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic scan_rd;
    logic scan_next;
    logic add;
    logic div_step;
    logic pick_rd;
    logic emit;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [1:0] req_type;
    logic       addr_zero;
    logic       cnt_zero;
    logic       hop_ok;
    logic       match;
    logic       scan_last;
    logic       div_last;
    logic       out_free;
  } stat_t;

endpackage

// File: sv/ntnh_chan_if.sv
// Valid/ready channel interface with a typed payload.
interface ntnh_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// File: sv/ntnh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ntnh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/ntnh_ctrl.sv
// Sequencing state machine of the next-hop selector.
module ntnh_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ntnh_pkg::stat_t stat,
  output ntnh_pkg::cmd_t  cmd
);

  ntnh_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ntnh_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ntnh_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ntnh_pkg::ST_DECODE;
        end
      end
      ntnh_pkg::ST_DECODE: begin
        case (stat.req_type)
          ntnh_pkg::REQ_BEACON: begin
            if (stat.addr_zero) begin
              state_nxt = ntnh_pkg::ST_FINISH;
            end else if (stat.cnt_zero) begin
              state_nxt = ntnh_pkg::ST_WRITE;
            end else begin
              state_nxt = ntnh_pkg::ST_SCAN_RD;
            end
          end
          ntnh_pkg::REQ_ORIGINATE: begin
            state_nxt = stat.cnt_zero ? ntnh_pkg::ST_FINISH : ntnh_pkg::ST_DIV;
          end
          ntnh_pkg::REQ_RELAY: begin
            state_nxt = (!stat.hop_ok || stat.cnt_zero) ? ntnh_pkg::ST_FINISH
                                                         : ntnh_pkg::ST_DIV;
          end
          default: begin
            state_nxt = ntnh_pkg::ST_FINISH;
          end
        endcase
      end
      ntnh_pkg::ST_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = ntnh_pkg::ST_SCAN_CMP;
      end
      ntnh_pkg::ST_SCAN_CMP: begin
        if (stat.match) begin
          state_nxt = ntnh_pkg::ST_FINISH;
        end else if (stat.scan_last) begin
          state_nxt = ntnh_pkg::ST_WRITE;
        end else begin
          cmd.scan_next = 1'b1;
          state_nxt     = ntnh_pkg::ST_SCAN_RD;
        end
      end
      ntnh_pkg::ST_WRITE: begin
        cmd.add   = 1'b1;
        state_nxt = ntnh_pkg::ST_FINISH;
      end
      ntnh_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = ntnh_pkg::ST_PICK;
        end
      end
      ntnh_pkg::ST_PICK: begin
        cmd.pick_rd = 1'b1;
        state_nxt   = ntnh_pkg::ST_FINISH;
      end
      ntnh_pkg::ST_FINISH: begin
        // wait until the result register can take the new result
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ntnh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ntnh_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/ntnh_dp.sv
// Datapath: neighbor table, fill count, bit-serial modulo and result register.
module ntnh_dp #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ntnh_pkg::cmd_t     cmd,
  output ntnh_pkg::stat_t    stat,
  input  ntnh_pkg::in_pay_t  in_pay,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  output logic               out_valid,
  input  logic               out_ready,
  output ntnh_pkg::out_pay_t out_pay
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int STEP_W = $clog2(ntnh_pkg::RAND_W);

  // Latched item
  logic [1:0]                   req_r;
  logic [15:0]                  addr_r;
  logic [7:0]                   hops_r;
  logic [ntnh_pkg::RAND_W-1:0]  rand_sh_r;

  logic [7:0]       hop_limit_r;
  logic [CNT_W-1:0] cnt_r;
  logic [IDX_W-1:0] wp_r, wp_nxt;
  logic [IDX_W-1:0] sp_r;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r;
  logic [15:0]      seq_r;
  logic             added_r;
  logic             out_valid_r;
  ntnh_pkg::out_pay_t out_pay_r, out_pay_nxt;

  logic [15:0]      rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   dvsr;
  logic             is_orig, is_relay, hop_ok, cnt_zero, want_send, send;

  // Neighbor table storage
  assign rd_addr = cmd.pick_rd ? rem_r[IDX_W-1:0] : sp_r;

  ntnh_ram #(
    .WIDTH(16),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (cmd.add),
    .waddr(wp_r),
    .wdata(addr_r),
    .re   (cmd.scan_rd | cmd.pick_rd),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // Decoded item
  assign is_orig   = (req_r == ntnh_pkg::REQ_ORIGINATE);
  assign is_relay  = (req_r == ntnh_pkg::REQ_RELAY);
  assign hop_ok    = (hops_r < hop_limit_r);
  assign cnt_zero  = (cnt_r == '0);
  assign want_send = is_orig | (is_relay & hop_ok);
  assign send      = want_send & ~cnt_zero;

  // Round-robin write pointer
  assign wp_nxt = (wp_r == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : wp_r + IDX_W'(1);

  // One restoring-division step of rand_value mod count
  assign trial   = {rem_r, rand_sh_r[ntnh_pkg::RAND_W-1]};
  assign dvsr    = {1'b0, cnt_r};
  assign rem_nxt = (trial >= dvsr) ? CNT_W'(trial - dvsr) : trial[CNT_W-1:0];

  // Status to the controller
  always_comb begin
    stat           = '0;
    stat.req_type  = req_r;
    stat.addr_zero = (addr_r == '0);
    stat.cnt_zero  = cnt_zero;
    stat.hop_ok    = hop_ok;
    stat.match     = (rd_data == addr_r);
    stat.scan_last = ((CNT_W'(sp_r) + CNT_W'(1)) == cnt_r);
    stat.div_last  = (step_r == STEP_W'(ntnh_pkg::RAND_W - 1));
    stat.out_free  = ~out_valid_r | out_ready;
  end

  // Result assembly
  always_comb begin
    out_pay_nxt               = '0;
    out_pay_nxt.send_now      = send;
    out_pay_nxt.next_hop      = send ? rd_data : '0;
    out_pay_nxt.out_hops      = (is_relay & hop_ok) ? hops_r + 8'd1 : '0;
    out_pay_nxt.seq_number    = is_orig ? seq_r : '0;
    out_pay_nxt.no_neighbor   = want_send & cnt_zero;
    out_pay_nxt.was_added     = added_r;
    out_pay_nxt.limit_reached = is_relay & ~hop_ok;
  end

  // Item capture, scan and modulo registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r     <= in_pay.req_type;
      addr_r    <= in_pay.neighbor_addr;
      hops_r    <= in_pay.hop_count;
      rand_sh_r <= in_pay.rand_value;
      sp_r      <= '0;
      rem_r     <= '0;
      step_r    <= '0;
    end else begin
      if (cmd.scan_next) begin
        sp_r <= sp_r + IDX_W'(1);
      end
      if (cmd.div_step) begin
        rem_r     <= rem_nxt;
        rand_sh_r <= {rand_sh_r[ntnh_pkg::RAND_W-2:0], 1'b0};
        step_r    <= step_r + STEP_W'(1);
      end
    end
    if (cmd.emit) begin
      out_pay_r <= out_pay_nxt;
    end
  end

  // Control state: config, table fill, sequence and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hop_limit_r <= ntnh_pkg::HOP_LIMIT_RESET;
      cnt_r       <= '0;
      wp_r        <= '0;
      seq_r       <= '0;
      added_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        hop_limit_r <= cfg_wdata;
      end
      if (cmd.load) begin
        added_r <= 1'b0;
      end else if (cmd.add) begin
        added_r <= 1'b1;
        wp_r    <= wp_nxt;
        if (cnt_r != CNT_W'(TABLE_ENTRIES)) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      if (cmd.emit && is_orig) begin
        seq_r <= seq_r + 16'd1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_pay   = out_pay_r;

endmodule

// File: sv/neighbor_table_next_hop_select.sv
// Neighbor table with random next-hop selection: one result per accepted
// item, one item at a time. From the cycle an item is taken until the next
// item can be taken: a dropped relay, an ignored code, a beacon from address
// zero or a send with an empty table goes straight to the result; an
// originate or forwarded relay with neighbors present runs the 16-step
// bit-serial modulo of rand_value by the neighbor count plus one table read;
// a beacon compares the sender against k stored entries (one table read and
// one compare each, k at most TABLE_ENTRIES), and a new sender is then
// written. The result sits in an output register, so the next item is taken
// while it waits. hop_limit resets to 20; the user is to write it through
// cfg_we/cfg_wdata only while idle, which the block does not enforce.
module neighbor_table_next_hop_select #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  ntnh_chan_if.sink          in_ch,
  ntnh_chan_if.source        out_ch,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);

  ntnh_pkg::cmd_t  cmd;
  ntnh_pkg::stat_t stat;

  // Sequencer
  ntnh_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // Table, arithmetic and result register
  ntnh_dp #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_pay   (in_ch.payload),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_pay  (out_ch.payload)
  );

endmodule

// File: sv/ntnh_checker.sv
// Port-level checker for the next-hop selector and its bind.
`include "assert_macros.svh"

module ntnh_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input ntnh_pkg::out_pay_t out_pay
);

  logic quiet_ante;
  logic quiet_ok;

  // Stored beacon or dropped relay, and what such a result must carry
  assign quiet_ante = out_valid && (out_pay.was_added || out_pay.limit_reached);
  assign quiet_ok   = !out_pay.send_now && out_pay.out_hops == 8'd0 &&
                      out_pay.seq_number == 16'd0;

  // A stalled result holds its value
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_pay))

  // One item in flight: no transfer in the cycle right after a transfer
  `ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)

  // A send and an empty-table flag never come together
  `ASSERT_IMP(a_send_excl, clk, rst_n, out_valid, !(out_pay.send_now && out_pay.no_neighbor))

  // No send means no next hop
  `ASSERT_IMP(a_hop_zero, clk, rst_n, out_valid && !out_pay.send_now, out_pay.next_hop == 16'd0)

  // Stored beacons and dropped relays send nothing and carry no counts
  `ASSERT_IMP(a_quiet, clk, rst_n, quiet_ante, quiet_ok)

endmodule

bind neighbor_table_next_hop_select ntnh_checker u_ntnh_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_pay  (out_ch.payload)
);
